@@ design/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("assertion failed");

// Condition must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("forbidden condition seen");

`endif

@@ design/mobm_pkg.sv @@
`default_nettype none
package mobm_pkg;

	typedef enum logic [1:0] {
		OP_REG_WR  = 2'd0,
		OP_WRAM_WR = 2'd1,
		OP_WRAM_RD = 2'd2,
		OP_TICK    = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		K_NONE      = 3'd0,
		K_PRG       = 3'd1,
		K_CHR       = 3'd2,
		K_MIRROR    = 3'd3,
		K_IRQ_RAISE = 3'd4,
		K_IRQ_CLEAR = 3'd5,
		K_READ      = 3'd6
	} kind_t;

	typedef enum logic [1:0] {
		CFG_PRG_COUNT   = 2'd0,
		CFG_CHR_COUNT   = 2'd1,
		CFG_MIRROR_MUTE = 2'd2
	} cfg_idx_t;

	localparam logic [15:0] RegMask     = 16'hE001;
	localparam logic [15:0] RegSelect   = 16'h8000;
	localparam logic [15:0] RegBankData = 16'h8001;
	localparam logic [15:0] RegMirror   = 16'hA000;
	localparam logic [15:0] RegRamCtrl  = 16'hA001;
	localparam logic [15:0] RegIrqLatch = 16'hC000;
	localparam logic [15:0] RegIrqRld   = 16'hC001;
	localparam logic [15:0] RegIrqOff   = 16'hE000;
	localparam logic [15:0] RegIrqOn    = 16'hE001;

	localparam logic [9:0]  PrgCountRst = 10'd32;
	localparam logic [11:0] ChrCountRst = 12'd256;

	// result index of the last PRG / last CHR word of a bank job
	localparam logic [3:0] PrgLastIdx = 4'd3;
	localparam logic [3:0] ChrLastIdx = 4'd11;
	localparam logic [3:0] ChrFirstIdx = 4'd4;

	// one unit of work for the back end
	typedef struct packed {
		logic            is_bank;  // expand into PRG/CHR slot words
		kind_t           kind;     // single-word jobs only
		logic            val;      // single-word value bit
		logic            sel6;     // PRG mode
		logic            sel7;     // CHR mode
		logic            outer;
		logic [7:0][7:0] banks;
	} job_t;

endpackage
`default_nettype wire

@@ design/mobm_front.sv @@
`default_nettype none
module mobm_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           accept,
	input  wire logic [1:0]     opcode,
	input  wire logic [15:0]    address,
	input  wire logic [7:0]     data,
	input  wire logic           rendering_enabled,
	input  wire logic           mirror_mute,
	output mobm_pkg::job_t      job,
	output logic                push
);

	logic [7:0]      select_q;
	logic [7:0][7:0] banks_q;
	logic            mirror_q;
	logic [7:0]      rld_value_q;
	logic [7:0]      irq_count_q;
	logic            rld_pend_q;
	logic            irq_enable_q;
	logic            outer_q;
	logic            ram_en_q;
	logic            ram_prot_q;

	logic [15:0]     reg_addr;
	logic [7:0]      irq_count_nx;
	logic            wram_ok;
	logic [7:0]      select_nx;
	logic [7:0][7:0] banks_nx;
	logic            outer_nx;

	assign reg_addr = address & mobm_pkg::RegMask;
	assign wram_ok  = ram_en_q && !ram_prot_q;
	assign irq_count_nx = (irq_count_q == 8'd0 || rld_pend_q) ? rld_value_q
		: irq_count_q - 8'd1;

	// state as it stands after this word; bank jobs snapshot it
	always_comb begin
		select_nx = select_q;
		banks_nx  = banks_q;
		outer_nx  = outer_q;
		if (mobm_pkg::opcode_t'(opcode) == mobm_pkg::OP_REG_WR) begin
			if (reg_addr == mobm_pkg::RegSelect)
				select_nx = data;
			if (reg_addr == mobm_pkg::RegBankData)
				banks_nx[select_q[2:0]] = data;
		end
		if (mobm_pkg::opcode_t'(opcode) == mobm_pkg::OP_WRAM_WR && wram_ok)
			outer_nx = data[0];
	end

	always_comb begin
		push        = 1'b0;
		job.is_bank = 1'b0;
		job.kind    = mobm_pkg::K_NONE;
		job.val     = 1'b0;
		job.sel6    = select_nx[6];
		job.sel7    = select_nx[7];
		job.outer   = outer_nx;
		job.banks   = banks_nx;
		case (mobm_pkg::opcode_t'(opcode))
			mobm_pkg::OP_REG_WR: begin
				case (reg_addr)
					mobm_pkg::RegSelect, mobm_pkg::RegBankData: begin
						push        = 1'b1;
						job.is_bank = 1'b1;
					end
					mobm_pkg::RegMirror: begin
						push     = !mirror_mute;
						job.kind = mobm_pkg::K_MIRROR;
						job.val  = data[0];
					end
					mobm_pkg::RegIrqOff: begin
						push     = 1'b1;
						job.kind = mobm_pkg::K_IRQ_CLEAR;
					end
					default: ;
				endcase
			end
			mobm_pkg::OP_WRAM_WR: begin
				push        = wram_ok;
				job.is_bank = 1'b1;
			end
			mobm_pkg::OP_WRAM_RD: begin
				push     = 1'b1;
				job.kind = mobm_pkg::K_READ;
				job.val  = outer_q;
			end
			mobm_pkg::OP_TICK: begin
				push     = rendering_enabled && irq_count_nx == 8'd0 && irq_enable_q;
				job.kind = mobm_pkg::K_IRQ_RAISE;
			end
			default: ;
		endcase
		push = push && accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			select_q     <= '0;
			banks_q      <= {8'd1, 56'd0};
			mirror_q     <= 1'b0;
			rld_value_q  <= '0;
			irq_count_q  <= '0;
			rld_pend_q   <= 1'b0;
			irq_enable_q <= 1'b0;
			outer_q      <= 1'b0;
			ram_en_q     <= 1'b0;
			ram_prot_q   <= 1'b0;
		end else if (accept) begin
			select_q <= select_nx;
			banks_q  <= banks_nx;
			outer_q  <= outer_nx;
			if (mobm_pkg::opcode_t'(opcode) == mobm_pkg::OP_REG_WR) begin
				case (reg_addr)
					mobm_pkg::RegMirror:   mirror_q <= data[0];
					mobm_pkg::RegRamCtrl: begin
						ram_en_q   <= data[7];
						ram_prot_q <= data[6];
					end
					mobm_pkg::RegIrqLatch: rld_value_q  <= data;
					mobm_pkg::RegIrqRld:   rld_pend_q   <= 1'b1;
					mobm_pkg::RegIrqOff:   irq_enable_q <= 1'b0;
					mobm_pkg::RegIrqOn:    irq_enable_q <= 1'b1;
					default: ;
				endcase
			end
			if (mobm_pkg::opcode_t'(opcode) == mobm_pkg::OP_TICK && rendering_enabled) begin
				irq_count_q <= irq_count_nx;
				rld_pend_q  <= 1'b0;
			end
		end
	end

	// mirror_q is kept for completeness of the register file; no read path
	logic unused_mirror;
	assign unused_mirror = mirror_q;

endmodule
`default_nettype wire

@@ design/mobm_queue.sv @@
`default_nettype none
`include "assert_macros.svh"
module mobm_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire mobm_pkg::job_t push_job,
	input  wire logic           pop,
	output mobm_pkg::job_t      head,
	output logic                empty,
	output logic                full
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	mobm_pkg::job_t mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == CntW'(DEPTH));
	assign head  = mem_q[rd_ptr_q];

	function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
		return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + CntW'(1);
			else if (pop && !push)
				count_q <= count_q - CntW'(1);
		end
	end

	`ASSERT_NEVER(a_no_push_full, clk, arst_n, push && full)
	`ASSERT_NEVER(a_no_pop_empty, clk, arst_n, pop && empty)

endmodule
`default_nettype wire

@@ design/mobm_back.sv @@
`default_nettype none
`include "assert_macros.svh"
module mobm_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire mobm_pkg::job_t head,
	input  wire logic           head_valid,
	output logic                pop,
	input  wire logic [9:0]     prg_total,
	input  wire logic [11:0]    chr_total,
	output logic                out_valid,
	input  wire logic           out_ready,
	output mobm_pkg::kind_t     out_kind,
	output logic [2:0]          out_slot,
	output logic [15:0]         out_value,
	output logic                out_last
);

	logic [3:0]  idx_q;
	logic        valid_q;
	mobm_pkg::kind_t kind_q;
	logic [2:0]  slot_q;
	logic [15:0] value_q;
	logic        last_q;

	logic        load;
	logic        is_prg;
	logic [3:0]  last_idx;
	logic [15:0] hp, hc, base, term;
	logic [2:0]  chr_slot;
	logic [1:0]  j;
	logic [7:0]  pair_reg, one_reg;
	logic [6:0]  chr_val;
	mobm_pkg::kind_t r_kind;
	logic [2:0]  r_slot;
	logic [15:0] r_value;
	logic        r_last;

	assign load     = head_valid && (!valid_q || out_ready);
	assign is_prg   = (idx_q[3:2] == 2'b00);
	assign last_idx = (chr_total != '0) ? mobm_pkg::ChrLastIdx : mobm_pkg::PrgLastIdx;

	// half sizes, forced to one when zero
	assign hp = (prg_total[9:1] == '0) ? 16'd1 : {7'd0, prg_total[9:1]};
	assign hc = (chr_total[11:1] == '0) ? 16'd1 : {5'd0, chr_total[11:1]};

	assign chr_slot = 3'(idx_q - mobm_pkg::ChrFirstIdx);
	assign j        = chr_slot[1:0];
	assign pair_reg = j[1] ? head.banks[1] : head.banks[0];
	assign one_reg  = head.banks[3'(j) + 3'd2];
	// CHR mode swaps the 2 KB pairs and the 1 KB banks between halves
	assign chr_val  = (chr_slot[2] == head.sel7) ? {pair_reg[6:1], j[0]} : one_reg[6:0];

	always_comb begin
		case (idx_q[1:0])
			2'd0:    term = head.sel6 ? hp - 16'd2 : {12'd0, head.banks[6][3:0]};
			2'd1:    term = {12'd0, head.banks[7][3:0]};
			2'd2:    term = head.sel6 ? {12'd0, head.banks[6][3:0]} : hp - 16'd2;
			default: term = hp - 16'd1;
		endcase
		if (!is_prg)
			term = {9'd0, chr_val};
		base = !head.outer ? 16'd0 : (is_prg ? hp : hc);
	end

	always_comb begin
		if (head.is_bank) begin
			r_kind  = is_prg ? mobm_pkg::K_PRG : mobm_pkg::K_CHR;
			r_slot  = is_prg ? idx_q[2:0] : chr_slot;
			r_value = base + term;
			r_last  = (idx_q == last_idx);
		end else begin
			r_kind  = head.kind;
			r_slot  = 3'd0;
			r_value = {15'd0, head.val};
			r_last  = 1'b1;
		end
	end

	assign pop = load && r_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= r_last ? 4'd0 : idx_q + 4'd1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q  <= r_kind;
			slot_q  <= r_slot;
			value_q <= r_value;
			last_q  <= r_last;
		end
	end

	assign out_valid = valid_q;
	assign out_kind  = kind_q;
	assign out_slot  = slot_q;
	assign out_value = value_q;
	assign out_last  = last_q;

	`ASSERT_HOLDS(a_idx_range, clk, arst_n, idx_q <= mobm_pkg::ChrLastIdx)
	`ASSERT_HOLDS(a_idx_rest_idle, clk, arst_n, !head_valid |-> idx_q == 4'd0)

endmodule
`default_nettype wire

@@ design/mmc3_outer_bank_mapper_top.sv @@
// channel | dir | handshake          | contents
// s       | in  | s_tvalid/s_tready  | bus event word: tuser opcode, tdata address/data/render
// m       | out | m_tvalid/m_tready  | mapping result word: tuser kind, tdata slot/value, tlast
// cfg     | in  | cfg_we             | bank counts and four-screen flag, write only
//
// Front end decodes one input word per cycle while the job queue has room.
// A bank change yields 4 result words (PRG only) or 12 (PRG and CHR) from the
// back end; every other job yields one. Sustained rate is set by the back end.
// Reset is asynchronous, active low, and puts all mapper state at its power-up
// value at once; no clearing pass is needed.
// Each side stalls on its own: the queue and the output register decouple them.
`default_nettype none
module mmc3_outer_bank_mapper_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [15:0] address, [23:16] data, [24] rendering_enabled
	input  wire logic [1:0]  s_tuser,   // [1:0] opcode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // [2:0] slot, [18:3] value
	output logic [2:0]       m_tuser,   // [2:0] kind
	output logic             m_tlast,   // last word of this event
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [11:0] cfg_data
);

	// configuration registers, user must write only while the mapper is idle; not enforced
	logic [9:0]  prg_total_q;
	logic [11:0] chr_total_q;
	logic        mirror_mute_q;

	logic            accept;
	logic            push;
	logic            pop;
	logic            q_empty;
	logic            q_full;
	mobm_pkg::job_t  push_job;
	mobm_pkg::job_t  head;
	mobm_pkg::kind_t out_kind;
	logic [2:0]      out_slot;
	logic [15:0]     out_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_total_q   <= mobm_pkg::PrgCountRst;
			chr_total_q   <= mobm_pkg::ChrCountRst;
			mirror_mute_q <= 1'b0;
		end else if (cfg_we) begin
			case (mobm_pkg::cfg_idx_t'(cfg_index))
				mobm_pkg::CFG_PRG_COUNT:   prg_total_q   <= cfg_data[9:0];
				mobm_pkg::CFG_CHR_COUNT:   chr_total_q   <= cfg_data;
				mobm_pkg::CFG_MIRROR_MUTE: mirror_mute_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// take a word whenever a job slot is free, even while results stall
	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	mobm_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.accept            (accept),
		.opcode            (s_tuser),
		.address           (s_tdata[15:0]),
		.data              (s_tdata[23:16]),
		.rendering_enabled (s_tdata[24]),
		.mirror_mute       (mirror_mute_q),
		.job               (push_job),
		.push              (push)
	);

	mobm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty),
		.full     (q_full)
	);

	mobm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (!q_empty),
		.pop        (pop),
		.prg_total  (prg_total_q),
		.chr_total  (chr_total_q),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_kind   (out_kind),
		.out_slot   (out_slot),
		.out_value  (out_value),
		.out_last   (m_tlast)
	);

	assign m_tuser = out_kind;
	assign m_tdata = {5'd0, out_value, out_slot};

	// s_tdata upper bits are padding
	logic unused_pad;
	assign unused_pad = ^s_tdata[31:25];

endmodule
`default_nettype wire

@@ test/tb_mmc3_outer_bank_mapper_top.sv @@
module tb_mmc3_outer_bank_mapper_top;
	timeunit 1ns;
	timeprecision 1ps;

	// index 3 of the config port maps to no register, it must be ignored
	localparam logic [1:0] CfgSpare = 2'd3;

	localparam int TailCycles    = 32;      // queue depth plus output stage, with margin
	localparam int HoldOffCycles = 300;     // long sink stall, fills the job queue
	localparam int PhaseEvents   = 75;      // random bus events per config setting
	localparam int Phases        = 6;
	localparam int RunLimitNs    = 2000000;
	localparam int ReportCap     = 100;

	// one result word as seen on the m side
	typedef struct packed {
		mobm_pkg::kind_t kind;
		logic [2:0]      slot;
		logic [15:0]     value;
		logic            last;
	} map_word_t;

	// directed stimulus row; typed rows carry their result, others go to the predictor
	typedef struct packed {
		mobm_pkg::opcode_t op;
		logic [15:0]       addr;
		logic [7:0]        data;
		logic              rend;
		logic              typed;
		logic              has_word;
		mobm_pkg::kind_t   kind;
		logic [15:0]       value;
	} probe_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [1:0]  s_tuser = mobm_pkg::OP_REG_WR;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = mobm_pkg::CFG_PRG_COUNT;
	logic [11:0] cfg_data = '0;

	// shadow of the offered word: typed expectation travels with the bus word
	logic        row_typed = 1'b0;
	logic        row_has_word = 1'b0;
	map_word_t   row_word = '0;

	logic        calm = 1'b0;       // no idling on either side
	int          hold_off_id = 0;   // bump to make the sink stall

	// mapper copy kept by the testbench
	logic [9:0]  prg_count;
	logic [11:0] chr_count;
	logic        four_scr;
	logic [7:0]  sel_reg;
	logic [7:0]  bank_reg [8];
	logic        mirror;
	logic [7:0]  rld_value;
	logic [7:0]  line_count;
	logic        rld_pend;
	logic        irq_on;
	logic        outer;
	logic        wram_en;
	logic        wram_wp;

	map_word_t   event_words [$];   // words of the event just accepted
	map_word_t   pending_map [$];   // words still due on the m side

	int          fail_count = 0;
	int          events_taken = 0;
	int          words_checked = 0;
	int          remap_count = 0;
	int          raise_count = 0;
	int          read_count = 0;

	probe_row_t  directed_rows [0:24];

	mmc3_outer_bank_mapper_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// mapper predictor
	// ---------------------------------------------------------------

	function automatic void reset_mapper_state();
		prg_count = mobm_pkg::PrgCountRst;
		chr_count = mobm_pkg::ChrCountRst;
		four_scr = 1'b0;
		sel_reg = '0;
		for (int i = 0; i < 8; i++) bank_reg[i] = '0;
		bank_reg[7] = 8'd1;
		mirror = 1'b0;
		rld_value = '0;
		line_count = '0;
		rld_pend = 1'b0;
		irq_on = 1'b0;
		outer = 1'b0;
		wram_en = 1'b0;
		wram_wp = 1'b0;
	endfunction

	function automatic void apply_config(logic [1:0] idx, logic [11:0] val);
		case (idx)
			mobm_pkg::CFG_PRG_COUNT:   prg_count = val[9:0];
			mobm_pkg::CFG_CHR_COUNT:   chr_count = val;
			mobm_pkg::CFG_MIRROR_MUTE: four_scr = val[0];
			default: ;
		endcase
	endfunction

	function automatic void queue_word(mobm_pkg::kind_t k, logic [2:0] s, logic [15:0] v);
		map_word_t w;
		w.kind = k;
		w.slot = s;
		w.value = v;
		w.last = 1'b0;
		event_words.push_back(w);
	endfunction

	// four 8 KB PRG slots, then eight 1 KB CHR slots when there is CHR ROM
	function automatic void emit_bank_map();
		logic [15:0] prg_half, chr_half, prg_off, chr_off;
		logic [15:0] r6_bank, r7_bank, fixed_last, fixed_second;
		logic [7:0]  pair_banks [4];
		logic [7:0]  single_banks [4];
		logic [7:0]  chr_bank;
		prg_half = {7'd0, prg_count[9:1]};
		chr_half = {5'd0, chr_count[11:1]};
		if (prg_half == 16'd0) prg_half = 16'd1;
		if (chr_half == 16'd0) chr_half = 16'd1;
		prg_off = outer ? prg_half : 16'd0;
		chr_off = outer ? chr_half : 16'd0;
		// all PRG sums are 16 bits wide and wrap on their own
		fixed_last = prg_off + prg_half - 16'd1;
		fixed_second = prg_off + prg_half - 16'd2;
		r6_bank = prg_off + {12'd0, bank_reg[6][3:0]};
		r7_bank = prg_off + {12'd0, bank_reg[7][3:0]};
		if (!sel_reg[6]) begin
			queue_word(mobm_pkg::K_PRG, 3'd0, r6_bank);
			queue_word(mobm_pkg::K_PRG, 3'd1, r7_bank);
			queue_word(mobm_pkg::K_PRG, 3'd2, fixed_second);
		end else begin
			queue_word(mobm_pkg::K_PRG, 3'd0, fixed_second);
			queue_word(mobm_pkg::K_PRG, 3'd1, r7_bank);
			queue_word(mobm_pkg::K_PRG, 3'd2, r6_bank);
		end
		queue_word(mobm_pkg::K_PRG, 3'd3, fixed_last);
		if (chr_count != 12'd0) begin
			// 2 KB pairs keep bit 0 for the pair half, inner range is 7 bits
			pair_banks[0] = {1'b0, bank_reg[0][6:1], 1'b0};
			pair_banks[1] = {1'b0, bank_reg[0][6:1], 1'b1};
			pair_banks[2] = {1'b0, bank_reg[1][6:1], 1'b0};
			pair_banks[3] = {1'b0, bank_reg[1][6:1], 1'b1};
			for (int i = 0; i < 4; i++) single_banks[i] = {1'b0, bank_reg[i + 2][6:0]};
			for (int i = 0; i < 8; i++) begin
				if (!sel_reg[7]) chr_bank = (i < 4) ? pair_banks[i] : single_banks[i - 4];
				else chr_bank = (i < 4) ? single_banks[i] : pair_banks[i - 4];
				queue_word(mobm_pkg::K_CHR, i[2:0], chr_off + {8'd0, chr_bank});
			end
		end
	endfunction

	// one bus event into the mapper copy; words land in event_words
	function automatic void step_mapper(mobm_pkg::opcode_t op, logic [15:0] addr,
			logic [7:0] data, logic rend);
		map_word_t w;
		case (op)
			mobm_pkg::OP_REG_WR: begin
				case (addr & mobm_pkg::RegMask)
					mobm_pkg::RegSelect: begin
						sel_reg = data;
						emit_bank_map();
					end
					mobm_pkg::RegBankData: begin
						bank_reg[sel_reg[2:0]] = data;
						emit_bank_map();
					end
					mobm_pkg::RegMirror: begin
						mirror = data[0];
						if (!four_scr) queue_word(mobm_pkg::K_MIRROR, 3'd0, {15'd0, mirror});
					end
					mobm_pkg::RegRamCtrl: begin
						wram_en = data[7];
						wram_wp = data[6];
					end
					mobm_pkg::RegIrqLatch: rld_value = data;
					mobm_pkg::RegIrqRld:   rld_pend = 1'b1;
					mobm_pkg::RegIrqOff: begin
						irq_on = 1'b0;
						queue_word(mobm_pkg::K_IRQ_CLEAR, 3'd0, 16'd0);
					end
					mobm_pkg::RegIrqOn:    irq_on = 1'b1;
					default: ;  // below the register window
				endcase
			end
			mobm_pkg::OP_WRAM_WR: begin
				if (wram_en && !wram_wp) begin
					outer = data[0];
					emit_bank_map();
				end
			end
			mobm_pkg::OP_WRAM_RD: queue_word(mobm_pkg::K_READ, 3'd0, {15'd0, outer});
			default: begin
				// scanline tick, only counts while rendering
				if (rend) begin
					if (line_count == 8'd0 || rld_pend) line_count = rld_value;
					else line_count = line_count - 8'd1;
					if (line_count == 8'd0 && irq_on)
						queue_word(mobm_pkg::K_IRQ_RAISE, 3'd0, 16'd0);
					rld_pend = 1'b0;
				end
			end
		endcase
		if (event_words.size() > 0) begin
			w = event_words.pop_back();
			w.last = 1'b1;
			event_words.push_back(w);
		end
	endfunction

	function automatic void check_word(logic [2:0] got_kind, logic [2:0] got_slot,
			logic [15:0] got_value, logic got_last);
		map_word_t want;
		if (pending_map.size() == 0) begin
			fail_count++;
			if (fail_count <= ReportCap)
				$error("unexpected word: kind %0d slot %0d value %0d last %0d",
					got_kind, got_slot, got_value, got_last);
			return;
		end
		want = pending_map.pop_front();
		words_checked++;
		if (want.kind == mobm_pkg::K_PRG && want.slot == 3'd3) remap_count++;
		if (want.kind == mobm_pkg::K_IRQ_RAISE) raise_count++;
		if (want.kind == mobm_pkg::K_READ) read_count++;
		if (got_kind !== want.kind) begin
			fail_count++;
			if (fail_count <= ReportCap)
				$error("kind mismatch: expected %0d, got %0d", want.kind, got_kind);
		end
		if (got_slot !== want.slot) begin
			fail_count++;
			if (fail_count <= ReportCap)
				$error("slot mismatch: expected %0d, got %0d", want.slot, got_slot);
		end
		if (got_value !== want.value) begin
			fail_count++;
			if (fail_count <= ReportCap)
				$error("value mismatch: expected %0d, got %0d", want.value, got_value);
		end
		if (got_last !== want.last) begin
			fail_count++;
			if (fail_count <= ReportCap)
				$error("last mismatch: expected %0d, got %0d", want.last, got_last);
		end
	endfunction

	// ---------------------------------------------------------------
	// monitor: config writes, accepted bus words, accepted result words
	// input side first so a same-edge result still finds its expectation
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) apply_config(cfg_index, cfg_data);
			if (s_tvalid && s_tready) begin
				events_taken++;
				step_mapper(mobm_pkg::opcode_t'(s_tuser), s_tdata[15:0], s_tdata[23:16],
					s_tdata[24]);
				if (row_typed) begin
					if (row_has_word) pending_map.push_back(row_word);
				end else begin
					foreach (event_words[i]) pending_map.push_back(event_words[i]);
				end
				event_words.delete();
			end
			if (m_tvalid && m_tready)
				check_word(m_tuser, m_tdata[2:0], m_tdata[18:3], m_tlast);
		end
	end

	// ---------------------------------------------------------------
	// sink: random back-pressure, plus one long hold-off on request
	// ---------------------------------------------------------------
	initial begin : sink
		int seen_hold;
		seen_hold = 0;
		forever begin
			@(posedge clk);
			if (hold_off_id != seen_hold) begin
				seen_hold = hold_off_id;
				m_tready <= 1'b0;
				repeat (HoldOffCycles) @(posedge clk);
			end
			m_tready <= calm || ($urandom_range(0, 99) >= 33);
		end
	end

	// ---------------------------------------------------------------
	// source side
	// ---------------------------------------------------------------

	// offer one bus word, return at the edge that takes it
	task automatic send_event(mobm_pkg::opcode_t op, logic [15:0] addr, logic [7:0] data,
			logic rend, logic typed, logic has_word, map_word_t typed_w);
		while (!calm && $urandom_range(0, 99) < 33) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, rend, data, addr};
		s_tuser <= op;
		row_typed <= typed;
		row_has_word <= has_word;
		row_word <= typed_w;
		do @(posedge clk); while (!s_tready);
	endtask

	// half register writes, mostly in the window, with latch and RAM control values that
	// let IRQs fire and the outer bit move; the rest is noise
	task automatic send_random_event();
		mobm_pkg::opcode_t op;
		logic [15:0]       addr;
		logic [7:0]        data;
		logic              rend;
		int                pick;
		pick = $urandom_range(0, 99);
		addr = 16'($urandom_range(0, 16'hFFFF));
		data = 8'($urandom_range(0, 255));
		rend = ($urandom_range(0, 9) != 0);
		if (pick < 50) begin
			op = mobm_pkg::OP_REG_WR;
			if ($urandom_range(0, 7) != 0) addr[15] = 1'b1;
			case (addr & mobm_pkg::RegMask)
				mobm_pkg::RegIrqLatch:
					if ($urandom_range(0, 3) != 0) data = 8'($urandom_range(0, 6));
				mobm_pkg::RegRamCtrl:
					if ($urandom_range(0, 3) != 0) data[7:6] = 2'b10;
				default: ;
			endcase
		end else if (pick < 65) begin
			op = mobm_pkg::OP_WRAM_WR;
		end else if (pick < 75) begin
			op = mobm_pkg::OP_WRAM_RD;
		end else begin
			op = mobm_pkg::OP_TICK;
		end
		send_event(op, addr, data, rend, 1'b0, 1'b0, '0);
	endtask

	// stop offering, wait for every due word, then let silent events retire
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_map.size() != 0) @(posedge clk);
		repeat (TailCycles) @(posedge clk);
	endtask

	// all three registers plus the unused index; block is idle here
	task automatic set_config(logic [11:0] prg, logic [11:0] chr, logic [11:0] four);
		cfg_we <= 1'b1;
		cfg_index <= mobm_pkg::CFG_PRG_COUNT;
		cfg_data <= prg;
		@(posedge clk);
		cfg_index <= mobm_pkg::CFG_CHR_COUNT;
		cfg_data <= chr;
		@(posedge clk);
		cfg_index <= mobm_pkg::CFG_MIRROR_MUTE;
		cfg_data <= four;
		@(posedge clk);
		cfg_index <= CfgSpare;
		cfg_data <= 12'($urandom_range(0, 12'hFFF));
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin : stimulus
		map_word_t tw;
		directed_rows = '{
			// read-back right after reset: outer bit is zero
			'{mobm_pkg::OP_WRAM_RD, 16'h0000, 8'h00, 1'b0, 1'b1, 1'b1, mobm_pkg::K_READ, 16'd0},
			'{mobm_pkg::OP_REG_WR, 16'h8000, 8'h00, 1'b0, 1'b0, 1'b0, mobm_pkg::K_NONE, 16'd0},
			// below the register window after masking: nothing comes out
			'{mobm_pkg::OP_REG_WR, 16'h7FFF, 8'hFF, 1'b1, 1'b1, 1'b0, mobm_pkg::K_NONE, 16'd0},
			'{mobm_pkg::OP_REG_WR, 16'h0000, 8'h00, 1'b0, 1'b1, 1'b0, mobm_pkg::K_NONE, 16'd0},
			'{mobm_pkg::OP_REG_WR, 16'hA000, 8'h01, 1'b0, 1'b1, 1'b1, mobm_pkg::K_MIRROR, 16'd1},
			// aliased mirroring address, only bit 0 of the data counts
			'{mobm_pkg::OP_REG_WR, 16'hBFFE, 8'hFE, 1'b0, 1'b1, 1'b1, mobm_pkg::K_MIRROR, 16'd0},
			'{mobm_pkg::OP_REG_WR, 16'hE000, 8'h00, 1'b0, 1'b1, 1'b1, mobm_pkg::K_IRQ_CLEAR,
				16'd0},
			// work RAM still disabled
			'{mobm_pkg::OP_WRAM_WR, 16'h0000, 8'h01, 1'b0, 1'b1, 1'b0, mobm_pkg::K_NONE, 16'd0},
			'{mobm_pkg::OP_REG_WR, 16'hA001, 8'hC0, 1'b0, 1'b1, 1'b0, mobm_pkg::K_NONE, 16'd0},
			// enabled but write protected
			'{mobm_pkg::OP_WRAM_WR, 16'h0000, 8'h01, 1'b0, 1'b1, 1'b0, mobm_pkg::K_NONE, 16'd0},
			'{mobm_pkg::OP_REG_WR, 16'hA001, 8'h80, 1'b0, 1'b1, 1'b0, mobm_pkg::K_NONE, 16'd0},
			'{mobm_pkg::OP_WRAM_WR, 16'hFFFF, 8'hFF, 1'b1, 1'b0, 1'b0, mobm_pkg::K_NONE, 16'd0},
			'{mobm_pkg::OP_WRAM_RD, 16'h0000, 8'h00, 1'b0, 1'b1, 1'b1, mobm_pkg::K_READ, 16'd1},
			// both mode bits, select R6, then R6 at its top value
			'{mobm_pkg::OP_REG_WR, 16'h8000, 8'hC6, 1'b0, 1'b0, 1'b0, mobm_pkg::K_NONE, 16'd0},
			'{mobm_pkg::OP_REG_WR, 16'h8001, 8'hFF, 1'b0, 1'b0, 1'b0, mobm_pkg::K_NONE, 16'd0},
			'{mobm_pkg::OP_REG_WR, 16'h8000, 8'h47, 1'b0, 1'b0, 1'b0, mobm_pkg::K_NONE, 16'd0},
			'{mobm_pkg::OP_REG_WR, 16'h9FFF, 8'h00, 1'b0, 1'b0, 1'b0, mobm_pkg::K_NONE, 16'd0},
			'{mobm_pkg::OP_REG_WR, 16'h8000, 8'h80, 1'b0, 1'b0, 1'b0, mobm_pkg::K_NONE, 16'd0},
			'{mobm_pkg::OP_REG_WR, 16'h8001, 8'hFF, 1'b0, 1'b0, 1'b0, mobm_pkg::K_NONE, 16'd0},
			// IRQ on, latch zero, reload: next rendered tick raises
			'{mobm_pkg::OP_REG_WR, 16'hFFFF, 8'h00, 1'b0, 1'b1, 1'b0, mobm_pkg::K_NONE, 16'd0},
			'{mobm_pkg::OP_REG_WR, 16'hC000, 8'h00, 1'b0, 1'b1, 1'b0, mobm_pkg::K_NONE, 16'd0},
			'{mobm_pkg::OP_REG_WR, 16'hC001, 8'h00, 1'b0, 1'b1, 1'b0, mobm_pkg::K_NONE, 16'd0},
			'{mobm_pkg::OP_TICK, 16'h0000, 8'h00, 1'b1, 1'b1, 1'b1, mobm_pkg::K_IRQ_RAISE, 16'd0},
			// rendering off: counter frozen
			'{mobm_pkg::OP_TICK, 16'hFFFF, 8'hFF, 1'b0, 1'b1, 1'b0, mobm_pkg::K_NONE, 16'd0},
			'{mobm_pkg::OP_WRAM_WR, 16'h0000, 8'h00, 1'b0, 1'b0, 1'b0, mobm_pkg::K_NONE, 16'd0}
		};

		reset_mapper_state();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			tw.kind = directed_rows[i].kind;
			tw.slot = 3'd0;
			tw.value = directed_rows[i].value;
			tw.last = 1'b1;
			send_event(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].data,
				directed_rows[i].rend, directed_rows[i].typed, directed_rows[i].has_word, tw);
		end
		drain();

		for (int p = 0; p < Phases; p++) begin
			case (p)
				0: set_config(12'd32, 12'd256, 12'd0);
				// smallest counts: PRG half forced to one, PRG math wraps, no CHR words
				1: set_config(12'd0, 12'd0, 12'd1);
				2: set_config(12'd512, 12'd2048, 12'd0);
				// every data bit high, values masked to register width
				3: set_config(12'hFFF, 12'hFFF, 12'hFFF);
				4: set_config(12'd2, 12'd1, 12'd0);
				default: set_config(12'($urandom_range(0, 512)), 12'($urandom_range(0, 2048)),
					12'($urandom_range(0, 1)));
			endcase
			if (p == 0) hold_off_id <= hold_off_id + 1;   // sink stalls while we keep offering
			if (p == 3) calm <= 1'b1;
			for (int n = 0; n < PhaseEvents; n++) begin
				if (p == 4 && n == PhaseEvents / 2) drain();  // source waits for all words
				send_random_event();
			end
			drain();
			if (p == 3) calm <= 1'b0;
		end

		$display("covered %0d bus events over %0d config settings, %0d result words compared",
			events_taken, Phases + 1, words_checked);
		$display("including %0d bank remaps, %0d irq raises, %0d read-backs",
			remap_count, raise_count, read_count);
		if (fail_count == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end

	// hang guard
	initial begin : watchdog
		#(RunLimitNs);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
